### src/vt4_pkg.sv
// Shared types and constants for the 4x4 vertex transform unit.
package vt4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int PW        = 2 * DW;
	localparam int SW        = PW + 2;

	// Divider: unsigned magnitude, two quotient bits per stage
	localparam int DIV_BITS  = 2;
	localparam int DIV_STG   = (DW + FRAC_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_NW    = DIV_STG * DIV_BITS;

	// Input to result: product, sum, saturate, divider stages, output register
	localparam int LATENCY   = DIV_STG + 4;

	localparam logic [1:0] OP_PROJ = 2'd0;
	localparam logic [1:0] OP_AFF  = 2'd1;
	localparam logic [1:0] OP_DIR  = 2'd2;
	localparam logic [1:0] OP_FULL = 2'd3;

	localparam logic signed [DW-1:0] ONE_FX  = DW'(1) << FRAC_BITS;
	localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic [1:0]           opcode;
		logic signed [DW-1:0] in_x;
		logic signed [DW-1:0] in_y;
		logic signed [DW-1:0] in_z;
		logic signed [DW-1:0] in_w;
	} vt4_in_t;

	typedef struct packed {
		logic signed [DW-1:0] out_x;
		logic signed [DW-1:0] out_y;
		logic signed [DW-1:0] out_z;
		logic signed [DW-1:0] out_w;
		logic                 divide_by_zero;
		logic                 overflow;
	} vt4_out_t;

	// Data that rides alongside the dividers
	typedef struct packed {
		logic [1:0]                 op;
		logic [3:0][DW-1:0]         res;
		logic [3:0]                 rov;
		logic [2:0]                 neg;
		logic                       dz;
	} vt4_side_t;

endpackage

### src/vt4_div.sv
// Pipelined unsigned restoring divider, DIV_BITS quotient bits per stage.
module vt4_div import vt4_pkg::*; (
	input  logic              clk,
	input  logic [DIV_NW-1:0] num,
	input  logic [DW-1:0]     den,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_NW-1:0] n_s [DIV_STG+1];
	logic [DW-1:0]     r_s [DIV_STG+1];
	logic [DW-1:0]     d_s [DIV_STG+1];

	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
		logic [DIV_NW-1:0] n_nx;
		logic [DW-1:0]     r_nx;

		// Dividend bits shift out the top while quotient bits fill in the bottom
		always_comb begin
			logic [DW:0] t;
			n_nx = n_s[k];
			r_nx = r_s[k];
			t    = '0;
			for (int i = 0; i < DIV_BITS; i++) begin
				t    = {r_nx, n_nx[DIV_NW-1]};
				n_nx = {n_nx[DIV_NW-2:0], 1'b0};
				if (t >= {1'b0, d_s[k]}) begin
					t       = t - {1'b0, d_s[k]};
					n_nx[0] = 1'b1;
				end
				r_nx = t[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			n_s[k+1] <= n_nx;
			r_s[k+1] <= r_nx;
			d_s[k+1] <= d_s[k];
		end
	end

	assign quo = n_s[DIV_STG];

endmodule

### src/vertex_transform_4x4_unit.sv
// Top level of the 4x4 matrix-vector transform pipeline.
//
//  channel  | handshake      | payload
//  ---------+----------------+--------------------------------------
//  input    | start, busy    | cmd    (opcode, in_x..in_w)
//  result   | done           | result (out_x..out_w, flags)
//  config   | cfg_we         | cfg_idx, cfg_data (two elements per write)
//
// One item enters every cycle; busy stays low. Each result passes through the
// product, sum, saturate and divider stages and the output register, and the
// projection dividers retire two quotient bits per stage.
// Reset loads the identity matrix and empties the pipeline.
// The receiver cannot stall; done is a one-cycle strobe per item.
module vertex_transform_4x4_unit import vt4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  vt4_in_t     cmd,
	output logic        done,
	output vt4_out_t    result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data
);

	logic signed [DW-1:0] m_q [4][4];

	// Register index: row in bits 2:1, column pair in bit 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					m_q[r][c] <= (r == c) ? ONE_FX : '0;
				end
			end
		end else if (cfg_we) begin
			m_q[cfg_idx[2:1]][{cfg_idx[0], 1'b0}] <= cfg_data[31:0];
			m_q[cfg_idx[2:1]][{cfg_idx[0], 1'b1}] <= cfg_data[63:32];
		end
	end

	assign busy = 1'b0;

	logic                 acc;
	logic signed [DW-1:0] v [4];
	assign acc  = start && !busy;
	assign v[0] = cmd.in_x;
	assign v[1] = cmd.in_y;
	assign v[2] = cmd.in_z;
	always_comb begin
		unique case (cmd.opcode)
			OP_FULL: v[3] = cmd.in_w;
			OP_DIR:  v[3] = '0;
			default: v[3] = ONE_FX;
		endcase
	end

	// Stage 1: sixteen products
	logic                 vld_s1, vld_s2, vld_s3;
	logic [1:0]           op_s1, op_s2, op_s3;
	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [SW-1:0] sum_s2 [4];
	logic [DW-1:0]        res_s3 [4];
	logic [3:0]           rov_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd.opcode;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[r][c] <= m_q[r][c] * v[c];
			end
		end
	end

	// Stage 2: exact row sums
	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		for (int r = 0; r < 4; r++) begin
			sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1])
				+ SW'(prod_s1[r][2]) + SW'(prod_s1[r][3]);
		end
	end

	// Stage 3: floor to FRAC_BITS and saturate
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sh;
		op_s3 <= op_s2;
		for (int r = 0; r < 4; r++) begin
			sh = sum_s2[r] >>> FRAC_BITS;
			if (sh > SW'(SAT_MAX)) begin
				res_s3[r] <= SAT_MAX;
				rov_s3[r] <= 1'b1;
			end else if (sh < SW'(SAT_MIN)) begin
				res_s3[r] <= SAT_MIN;
				rov_s3[r] <= 1'b1;
			end else begin
				res_s3[r] <= sh[DW-1:0];
				rov_s3[r] <= 1'b0;
			end
		end
	end

	// Dividers take magnitudes straight from stage 3
	logic [DW-1:0]     wmag;
	logic [DIV_NW-1:0] quo [3];
	assign wmag = res_s3[3][DW-1] ? DW'(-res_s3[3]) : res_s3[3];

	for (genvar r = 0; r < 3; r++) begin : g_div
		logic [DW-1:0] xmag;
		assign xmag = res_s3[r][DW-1] ? DW'(-res_s3[r]) : res_s3[r];
		vt4_div u_div (
			.clk (clk),
			.num (DIV_NW'(xmag) << FRAC_BITS),
			.den (wmag),
			.quo (quo[r])
		);
	end

	vt4_side_t side_in;
	vt4_side_t side_s [DIV_STG];
	logic      vld_d  [DIV_STG];

	always_comb begin
		side_in.op  = op_s3;
		side_in.rov = rov_s3;
		side_in.dz  = (res_s3[3] == '0);
		for (int r = 0; r < 4; r++) begin
			side_in.res[r] = res_s3[r];
		end
		for (int r = 0; r < 3; r++) begin
			side_in.neg[r] = res_s3[r][DW-1] ^ res_s3[3][DW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STG; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else begin
			vld_d[0] <= vld_s3;
			for (int k = 1; k < DIV_STG; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < DIV_STG; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Final stage: sign, saturate quotients, pick per opcode
	vt4_side_t            sd;
	vt4_out_t             out_nx;
	logic [DW-1:0]        qv [3];
	logic [2:0]           qov;
	assign sd = side_s[DIV_STG-1];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			qov[r] = 1'b0;
			if (sd.neg[r]) begin
				// a negative quotient may reach a magnitude of 2^31
				if (quo[r] > {{(DIV_NW-DW){1'b0}}, SAT_MIN}) begin
					qv[r]  = SAT_MIN;
					qov[r] = 1'b1;
				end else begin
					qv[r] = DW'(-quo[r][DW-1:0]);
				end
			end else if (quo[r] > DIV_NW'(SAT_MAX)) begin
				qv[r]  = SAT_MAX;
				qov[r] = 1'b1;
			end else begin
				qv[r] = quo[r][DW-1:0];
			end
		end

		out_nx.divide_by_zero = 1'b0;
		out_nx.out_w          = '0;
		out_nx.out_x          = sd.res[0];
		out_nx.out_y          = sd.res[1];
		out_nx.out_z          = sd.res[2];
		out_nx.overflow       = |sd.rov[2:0];
		unique case (sd.op)
			OP_PROJ: begin
				if (sd.dz) begin
					out_nx.out_x          = '0;
					out_nx.out_y          = '0;
					out_nx.out_z          = '0;
					out_nx.overflow       = 1'b0;
					out_nx.divide_by_zero = 1'b1;
				end else begin
					out_nx.out_x    = qv[0];
					out_nx.out_y    = qv[1];
					out_nx.out_z    = qv[2];
					out_nx.overflow = (|sd.rov) | (|qov);
				end
			end
			OP_FULL: begin
				out_nx.out_w    = sd.res[3];
				out_nx.overflow = |sd.rov;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_d[DIV_STG-1];
		end
	end

	always_ff @(posedge clk) begin
		result <= out_nx;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LATENCY done)
		else $error("item did not produce a result after the pipeline latency");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> result.out_x == '0 && result.out_y == '0
			&& result.out_z == '0 && result.out_w == '0 && !result.overflow)
		else $error("zero divisor result not cleared");

	a_w_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.out_w != '0 |-> !result.divide_by_zero)
		else $error("w output and zero divisor flag together");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_d[DIV_STG-1]))
		else $error("result strobe without an item in flight");

endmodule
